[rtl/tipk_pkg.sv]
// Shared types and constants of the ternarizing im2row packer.
`timescale 1ns / 1ps
package tipk_pkg;

	localparam int WORD_BITS        = 64;
	localparam int DEF_MAX_ROWS     = 32;
	localparam int DEF_MAX_COLS     = 32;
	localparam int DEF_MAX_CHANNELS = 128;

	// Field widths fixed by the item format.
	localparam int SAMPLE_W  = 16;
	localparam int THRESH_W  = 15;
	localparam int COUNT_W   = 8;
	localparam int GEOM_W    = 3;
	localparam int BLK_W     = 3;
	localparam int BIT_IDX_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// Register reset values.
	localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 8'd64;
	localparam logic [GEOM_W-1:0]  RST_PAD           = 3'd0;
	localparam logic [GEOM_W-1:0]  RST_KERNEL        = 3'd3;
	localparam logic [GEOM_W-1:0]  RST_STEP          = 3'd1;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t neg;
		word_t nz;
	} word_pair_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT,
		REG_PAD_ROWS,
		REG_PAD_COLS,
		REG_KERNEL_ROWS,
		REG_KERNEL_COLS,
		REG_STEP_ROWS,
		REG_STEP_COLS
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD,
		KIND_FETCH
	} kind_t;

endpackage

[rtl/tipk_if.sv]
// Request and result channel interfaces of the ternarizing im2row packer.
`timescale 1ns / 1ps
interface tipk_req_if;
	import tipk_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic signed [SAMPLE_W-1:0]  sample;
	logic [THRESH_W-1:0]         threshold;
	logic                        row_end;
	logic                        image_end;
	modport source (output valid, kind, sample, threshold, row_end, image_end, input ready);
	modport sink (input valid, kind, sample, threshold, row_end, image_end, output ready);
endinterface

interface tipk_rsp_if;
	import tipk_pkg::*;
	logic  valid;
	logic  ready;
	word_t negative_mask;
	word_t nonzero_mask;
	logic  final_word;
	logic  valid_res;
	modport source (output valid, negative_mask, nonzero_mask, final_word, valid_res,
		input ready);
	modport sink (input valid, negative_mask, nonzero_mask, final_word, valid_res,
		output ready);
endinterface

[rtl/tipk_store.sv]
// Packed word pair memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tipk_store
	import tipk_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_pair_t    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output word_pair_t    rdata
);

	word_pair_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/ternarize_im2row_packer_unit.sv]
// Top level of the ternarizing im2row packer.
// Usage: configure the geometry registers through cfg_we/cfg_index/cfg_data while
// the block is idle. Then stream one image, channel-last, on req with kind = load,
// one sample per item, marking the last sample of each row with row_end and the
// last sample of the image with image_end. Each sample is ternarized and packed
// into 64-channel word pairs held in an on-chip memory.
// Each req item with kind = fetch produces one item on rsp: the next im2row word
// pair in output row, output column, kernel row, kernel column, channel block order.
// Padding positions read as zero words; an invalid fetch gives an all-zero item.
// A load item gives no result. A fetch item reads the memory at its accept edge,
// and its result is then registered in the output register, where it is valid on
// rsp until taken. req is held off while the store read is outstanding, so a new
// fetch is not taken before the last one has reached the output register; loads
// are taken one per cycle while no fetch is in flight and rsp does not stall.
// The registered read of the store is what holds req off between fetches.
// If rsp stalls, its output register holds the result and req stops accepting
// items until the result is taken. Reset clears all control state and restores
// the register defaults; the memory contents are not cleared.
`timescale 1ns / 1ps
module ternarize_im2row_packer_unit
	import tipk_pkg::*;
#(
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int MAX_COLS     = DEF_MAX_COLS,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tipk_req_if.sink              req,
	tipk_rsp_if.source            rsp
);

	localparam int BLOCKS = (MAX_CHANNELS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS * BLOCKS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W  = $clog2(MAX_COLS + 1);
	localparam int H_W    = $clog2(MAX_ROWS + 2);
	localparam int W_W    = $clog2(MAX_COLS + 2);
	localparam int E_W    = $clog2(MAX_ROWS + MAX_COLS + 32);
	localparam int PW     = E_W + 3;

	// Configuration registers.
	logic [COUNT_W-1:0] cc_q;
	logic [GEOM_W-1:0]  pr_q, pc_q, kr_q, kc_q, sr_q, sc_q;

	// Load state.
	word_t              pack_neg_q, pack_nz_q;
	logic [COUNT_W-1:0] pos_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [H_W-1:0]     height_q;
	logic [W_W-1:0]     width_q;
	logic               ready_q, ovf_q, wknown_q;

	// Fetch position.
	logic [E_W-1:0]     oh_q, ow_q;
	logic [GEOM_W-1:0]  kh_q, kw_q;
	logic [BLK_W-1:0]   cb_q;

	// Fetch pipeline and output register.
	logic               fetch_s1, in_image_s1, last_s1, ok_s1;
	logic               res_valid_q, last_q, vres_q;
	word_t              neg_q, nz_q;

	logic               req_acc, load_acc, fetch_acc;
	word_pair_t         rdata;

	assign req.ready = !fetch_s1 && (!res_valid_q || rsp.ready);
	assign req_acc   = req.valid && req.ready;
	assign load_acc  = req_acc && (kind_t'(req.kind) == KIND_LOAD);
	assign fetch_acc = req_acc && (kind_t'(req.kind) == KIND_FETCH);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= RST_CHANNEL_COUNT;
			pr_q <= RST_PAD;
			pc_q <= RST_PAD;
			kr_q <= RST_KERNEL;
			kc_q <= RST_KERNEL;
			sr_q <= RST_STEP;
			sc_q <= RST_STEP;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHANNEL_COUNT: cc_q <= cfg_data;
				REG_PAD_ROWS:      pr_q <= cfg_data[GEOM_W-1:0];
				REG_PAD_COLS:      pc_q <= cfg_data[GEOM_W-1:0];
				REG_KERNEL_ROWS:   kr_q <= cfg_data[GEOM_W-1:0];
				REG_KERNEL_COLS:   kc_q <= cfg_data[GEOM_W-1:0];
				REG_STEP_ROWS:     sr_q <= cfg_data[GEOM_W-1:0];
				REG_STEP_COLS:     sc_q <= cfg_data[GEOM_W-1:0];
				default: ;
			endcase
		end
	end

	// Load path: a complete image restarts on its next load.
	word_t              pack_neg_e, pack_nz_e, pack_neg_n, pack_nz_n, onehot;
	logic [COUNT_W-1:0] pos_e;
	logic [ROW_W-1:0]   row_e;
	logic [COL_W-1:0]   col_e;
	logic [H_W-1:0]     height_e;
	logic [W_W-1:0]     width_e;
	logic               ovf_e, wk_e, in_bounds, pix_end, flush, mark;
	logic signed [SAMPLE_W:0] s_x, t_x;
	logic               wr_en;
	logic [AW-1:0]      waddr;

	always_comb begin
		pos_e      = ready_q ? '0 : pos_q;
		row_e      = ready_q ? '0 : row_q;
		col_e      = ready_q ? '0 : col_q;
		pack_neg_e = ready_q ? '0 : pack_neg_q;
		pack_nz_e  = ready_q ? '0 : pack_nz_q;
		height_e   = ready_q ? '0 : height_q;
		width_e    = ready_q ? '0 : width_q;
		ovf_e      = ready_q ? 1'b0 : ovf_q;
		wk_e       = ready_q ? 1'b0 : wknown_q;
		in_bounds  = (int'(row_e) < MAX_ROWS) && (int'(col_e) < MAX_COLS) &&
			(int'(pos_e) < MAX_CHANNELS);
		s_x        = {req.sample[SAMPLE_W-1], req.sample};
		t_x        = signed'({2'b00, req.threshold});
		onehot     = word_t'(1) << pos_e[BIT_IDX_W-1:0];
		pack_neg_n = pack_neg_e;
		pack_nz_n  = pack_nz_e;
		if (s_x > t_x) begin
			pack_nz_n = pack_nz_e | onehot;
		end else if (s_x < -t_x) begin
			pack_neg_n = pack_neg_e | onehot;
			pack_nz_n  = pack_nz_e | onehot;
		end
		mark    = req.row_end || req.image_end;
		pix_end = ({1'b0, pos_e} + 9'd1 >= {1'b0, cc_q}) || mark;
		flush   = pix_end || (pos_e[BIT_IDX_W-1:0] == {BIT_IDX_W{1'b1}});
		wr_en   = load_acc && flush && in_bounds;
		waddr   = AW'((int'(row_e) * MAX_COLS + int'(col_e)) * BLOCKS +
			int'(pos_e >> BIT_IDX_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_neg_q <= '0;
			pack_nz_q  <= '0;
			pos_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			height_q   <= '0;
			width_q    <= '0;
			ready_q    <= 1'b0;
			ovf_q      <= 1'b0;
			wknown_q   <= 1'b0;
		end else if (load_acc) begin
			pack_neg_q <= flush ? '0 : pack_neg_n;
			pack_nz_q  <= flush ? '0 : pack_nz_n;
			ovf_q      <= ovf_e || !in_bounds;
			height_q   <= height_e;
			width_q    <= width_e;
			wknown_q   <= wk_e;
			ready_q    <= 1'b0;
			row_q      <= row_e;
			col_q      <= col_e;
			pos_q      <= pos_e + 1'b1;
			if (mark) begin
				if (row_e == '0 && !wk_e) begin
					width_q  <= W_W'(col_e) + 1'b1;
					wknown_q <= 1'b1;
				end
				pos_q <= '0;
				col_q <= '0;
				if (req.image_end) begin
					height_q <= H_W'(row_e) + 1'b1;
					ready_q  <= 1'b1;
					row_q    <= '0;
				end else if (int'(row_e) < MAX_ROWS) begin
					row_q <= row_e + 1'b1;
				end
			end else if (pix_end) begin
				pos_q <= '0;
				if (int'(col_e) < MAX_COLS) begin
					col_q <= col_e + 1'b1;
				end
			end
		end
	end

	// Fetch path: geometry check, window position and store address.
	logic [PW-1:0]      ph, pw, span_r, span_c, rb, cbs, rb_e, cbs_e, r, c;
	logic [BLK_W-1:0]   blocks, cb_e;
	logic [E_W-1:0]     oh_e, ow_e;
	logic [GEOM_W-1:0]  kh_e, kw_e;
	logic               geo_ok, wrap, in_image, last;
	logic [AW-1:0]      raddr;

	always_comb begin
		ph     = PW'(height_q) + PW'({pr_q, 1'b0});
		pw     = PW'(width_q) + PW'({pc_q, 1'b0});
		blocks = BLK_W'(({1'b0, cc_q} + 9'd63) >> BIT_IDX_W);
		geo_ok = ready_q && !ovf_q && (cc_q != '0) && (int'(cc_q) <= MAX_CHANNELS) &&
			(kr_q != '0) && (kc_q != '0) && (sr_q != '0) && (sc_q != '0) &&
			(ph >= PW'(kr_q)) && (pw >= PW'(kc_q));
		span_r = ph - PW'(kr_q);
		span_c = pw - PW'(kc_q);
		rb     = PW'(oh_q) * PW'(sr_q);
		cbs    = PW'(ow_q) * PW'(sc_q);
		wrap   = (rb > span_r) || (cbs > span_c) || (kh_q >= kr_q) || (kw_q >= kc_q) ||
			(cb_q >= blocks);
		oh_e   = wrap ? '0 : oh_q;
		ow_e   = wrap ? '0 : ow_q;
		kh_e   = wrap ? '0 : kh_q;
		kw_e   = wrap ? '0 : kw_q;
		cb_e   = wrap ? '0 : cb_q;
		rb_e   = wrap ? '0 : rb;
		cbs_e  = wrap ? '0 : cbs;
		r      = rb_e + PW'(kh_e);
		c      = cbs_e + PW'(kw_e);
		in_image = (r >= PW'(pr_q)) && (r < PW'(pr_q) + PW'(height_q)) &&
			(c >= PW'(pc_q)) && (c < PW'(pc_q) + PW'(width_q));
		raddr  = AW'((int'(r - PW'(pr_q)) * MAX_COLS + int'(c - PW'(pc_q))) * BLOCKS +
			int'(cb_e));
		last   = (rb_e + PW'(sr_q) > span_r) && (cbs_e + PW'(sc_q) > span_c) &&
			(kh_e + 1'b1 == kr_q) && (kw_e + 1'b1 == kc_q) && (cb_e + 1'b1 == blocks);
	end

	// Fetch position update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oh_q <= '0;
			ow_q <= '0;
			kh_q <= '0;
			kw_q <= '0;
			cb_q <= '0;
		end else if ((load_acc && (ready_q || req.image_end)) ||
			(fetch_acc && geo_ok && last)) begin
			oh_q <= '0;
			ow_q <= '0;
			kh_q <= '0;
			kw_q <= '0;
			cb_q <= '0;
		end else if (fetch_acc && geo_ok) begin
			oh_q <= oh_e;
			ow_q <= ow_e;
			kh_q <= kh_e;
			kw_q <= kw_e;
			cb_q <= cb_e + 1'b1;
			if (cb_e + 1'b1 >= blocks) begin
				cb_q <= '0;
				kw_q <= kw_e + 1'b1;
				if (kw_e + 1'b1 >= kc_q) begin
					kw_q <= '0;
					kh_q <= kh_e + 1'b1;
					if (kh_e + 1'b1 >= kr_q) begin
						kh_q <= '0;
						ow_q <= ow_e + 1'b1;
						if (cbs_e + PW'(sc_q) > span_c) begin
							ow_q <= '0;
							oh_q <= oh_e + 1'b1;
						end
					end
				end
			end
		end
	end

	tipk_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ('{neg: pack_neg_n, nz: pack_nz_n}),
		.re    (fetch_acc && geo_ok && in_image),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Stage one: wait for the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s1 <= 1'b0;
		end else begin
			fetch_s1 <= fetch_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_acc) begin
			ok_s1       <= geo_ok;
			in_image_s1 <= geo_ok && in_image;
			last_s1     <= geo_ok && last;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fetch_s1) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_s1) begin
			neg_q  <= in_image_s1 ? rdata.neg : '0;
			nz_q   <= in_image_s1 ? rdata.nz : '0;
			last_q <= last_s1;
			vres_q <= ok_s1;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.negative_mask = neg_q;
	assign rsp.nonzero_mask  = nz_q;
	assign rsp.final_word    = last_q;
	assign rsp.valid_res     = vres_q;

	// A fetch in flight always lands in the output register.
	a_fetch_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_s1 |=> res_valid_q)
		else $error("fetch result lost");

	// No item is taken while a store read is outstanding.
	a_fetch_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_s1 |-> !req.ready)
		else $error("item accepted during fetch");

	// The store is only written by an accepted load item.
	a_write_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (req_acc && (kind_t'(req.kind) == KIND_LOAD)))
		else $error("store written without load");

	// An invalid result carries all-zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !vres_q) |-> (neg_q == '0 && nz_q == '0 && !last_q))
		else $error("invalid result not zero");

endmodule
